### sv/clpe_pkg.sv
// Package for the circular list positional engine: operation and status codes,
// default capacity and field widths. No dependencies.
package clpe_pkg;

  localparam int unsigned DefaultCapacity = 32;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned PosWidth        = 6;
  localparam int unsigned CountWidth      = 6;

  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_NOP6      = 3'd6,
    KIND_NOP7      = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_UNDER = 2'd2,
    ST_BOUND = 2'd3
  } status_e;

endpackage

### sv/circular_list_positional_engine.sv
// Circular list positional engine: one request at a time, each request is
// answered by exactly one result. The list lives in a value memory and a link
// memory, each read through a registered port; free slots sit on a stack held
// in a third memory. Front and back values are kept in registers. A request
// that is refused or has an unused kind goes straight to the result; an insert
// at the front, at the back or into an empty list, and a delete at the front,
// need no walk. A positional insert or delete, or a delete at the back, at a
// position past 1 first walks the link memory from the front, one hop at a
// time. The free stack is filled in a pass after reset, during which no request
// is accepted. The result sits in an output register; the next request is
// accepted once it is taken, at the earliest in the cycle it is taken.
// Depends on clpe_pkg.
module circular_list_positional_engine #(
  parameter int unsigned CAPACITY = clpe_pkg::DefaultCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: value[31:0], position[37:32], zero fill [39:38]
  input  logic [39:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: count[5:0], front_value[37:6], back_value[69:38], zero fill [71:70]
  output logic [71:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned VW  = clpe_pkg::ValueWidth;
  localparam int unsigned OCW = clpe_pkg::CountWidth;
  // width for position and count compares
  localparam int unsigned RW  =
    ((CW > clpe_pkg::PosWidth) ? CW : clpe_pkg::PosWidth) + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK_RD, S_WALK_WT, S_INS_POP, S_INS_WR,
    S_DEL_RD, S_DEL_WT, S_DEL_LNK, S_DEL_FIX, S_DEL_VAL, S_DONE
  } state_e;

  // memories
  logic [VW-1:0] val_mem [CAPACITY];
  logic [SW-1:0] link_mem [CAPACITY];
  logic [SW-1:0] free_mem [CAPACITY];

  logic          val_we, link_we, free_we;
  logic [SW-1:0] val_wa, link_wa, free_wa, link_ra, free_ra;
  logic [VW-1:0] val_wd;
  logic [SW-1:0] link_wd, free_wd;
  logic [SW-1:0] link_rd_q, free_rd_q;
  logic [SW-1:0] val_ra;
  logic [VW-1:0] val_rd_q;

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (free_we) free_mem[free_wa] <= free_wd;
    link_rd_q <= link_mem[link_ra];
    free_rd_q <= free_mem[free_ra];
    val_rd_q  <= val_mem[val_ra];
  end

  state_e            state_q;
  logic [SW-1:0]     front_q, back_q, cur_q, slot_q, init_q;
  logic [CW-1:0]     cnt_q, free_top_q, hops_q;
  logic [VW-1:0]     front_v_q, back_v_q, value_q;
  logic              ins_q, first_q;
  clpe_pkg::status_e st_q;
  logic              ovalid_q;
  logic [71:0]       odata_q;
  logic [1:0]        ouser_q;

  clpe_pkg::kind_e   kind;
  logic [VW-1:0]     in_val;
  logic [RW-1:0]     in_pos, cnt_x, req_pos;
  logic              is_ins, is_del, req_app;
  clpe_pkg::status_e req_st;
  state_e            req_next;

  assign kind   = clpe_pkg::kind_e'(s_axis_tuser);
  assign in_val = s_axis_tdata[31:0];
  assign in_pos = RW'(s_axis_tdata[37:32]);
  assign cnt_x  = RW'(cnt_q);

  assign s_axis_tready = (state_q == S_IDLE) && !(ovalid_q && !m_axis_tready);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // request decode: effective position, status and first state
  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    req_pos = in_pos;
    unique case (kind)
      clpe_pkg::KIND_INS_FRONT: begin
        is_ins  = 1'b1;
        req_pos = RW'(1);
      end
      clpe_pkg::KIND_INS_BACK: begin
        is_ins  = 1'b1;
        req_pos = cnt_x + RW'(1);
      end
      clpe_pkg::KIND_INS_POS: is_ins = 1'b1;
      clpe_pkg::KIND_DEL_FRONT: begin
        is_del  = 1'b1;
        req_pos = RW'(1);
      end
      clpe_pkg::KIND_DEL_BACK: begin
        is_del  = 1'b1;
        req_pos = cnt_x;
      end
      clpe_pkg::KIND_DEL_POS: is_del = 1'b1;
      default: ;
    endcase
    // append goes after back directly
    req_app  = is_ins && (cnt_q != '0) && (req_pos == cnt_x + RW'(1));
    req_st   = clpe_pkg::ST_OK;
    req_next = S_DONE;
    if (is_ins) begin
      if (cnt_x >= RW'(CAPACITY)) req_st = clpe_pkg::ST_FULL;
      else if (req_pos == '0 || req_pos > cnt_x + RW'(1)) req_st = clpe_pkg::ST_BOUND;
      else if (req_app || req_pos < RW'(2)) req_next = S_INS_POP;
      else req_next = S_WALK_RD;
    end else if (is_del) begin
      if (cnt_q == '0) req_st = clpe_pkg::ST_UNDER;
      else if (req_pos == '0 || req_pos > cnt_x) req_st = clpe_pkg::ST_BOUND;
      else if (req_pos < RW'(2)) req_next = S_DEL_RD;
      else req_next = S_WALK_RD;
    end
  end

  // memory port control
  always_comb begin
    val_we = 1'b0; val_wa = free_rd_q; val_wd = value_q;
    link_we = 1'b0; link_wa = cur_q; link_wd = slot_q;
    free_we = 1'b0; free_wa = init_q; free_wd = init_q;
    link_ra = cur_q;
    free_ra = SW'(free_top_q - CW'(1));
    val_ra  = first_q ? link_rd_q : cur_q;
    unique case (state_q)
      S_INIT: free_we = 1'b1;
      S_INS_WR: begin
        val_we = 1'b1;
        link_we = 1'b1; link_wa = free_rd_q;
        // new node link
        if (cnt_q == '0) link_wd = free_rd_q;
        else if (first_q) link_wd = front_q;
        else link_wd = link_rd_q;
      end
      S_DEL_LNK: link_ra = slot_q;
      S_DEL_FIX: begin
        // unlink victim, push its slot
        link_we = 1'b1;
        link_wa = first_q ? back_q : cur_q;
        link_wd = link_rd_q;
        free_we = 1'b1; free_wa = SW'(free_top_q); free_wd = slot_q;
      end
      S_DONE: begin
        // predecessor (or back for a front insert) points to the new node
        if (ins_q && cnt_q != CW'(1)) begin
          link_we = 1'b1;
          link_wa = first_q ? back_q : cur_q;
          link_wd = slot_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; init_q <= '0; front_q <= '0; back_q <= '0;
      cnt_q <= '0; free_top_q <= CW'(CAPACITY); ovalid_q <= 1'b0;
      cur_q <= '0; slot_q <= '0; hops_q <= '0; ins_q <= 1'b0; first_q <= 1'b0;
      st_q <= clpe_pkg::ST_OK; value_q <= '0; front_v_q <= '0; back_v_q <= '0;
      odata_q <= '0; ouser_q <= '0;
    end else begin
      // result register
      if (state_q == S_DONE) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + SW'(1);
          if (init_q == SW'(CAPACITY - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            value_q <= in_val;
            cur_q   <= req_app ? back_q : front_q;
            st_q    <= req_st;
            ins_q   <= is_ins && (req_st == clpe_pkg::ST_OK);
            first_q <= (req_pos == RW'(1));
            hops_q  <= (req_pos >= RW'(2) && !req_app) ? CW'(req_pos - RW'(2)) : '0;
            state_q <= req_next;
          end
        end
        // walk: one hop per pass through S_WALK_RD and S_WALK_WT
        S_WALK_RD: begin
          if (hops_q == '0) state_q <= ins_q ? S_INS_POP : S_DEL_RD;
          else state_q <= S_WALK_WT;
        end
        S_WALK_WT: begin
          cur_q <= link_rd_q; hops_q <= hops_q - CW'(1); state_q <= S_WALK_RD;
        end
        // free stack read and link read of cur both in flight
        S_INS_POP: state_q <= S_INS_WR;
        S_INS_WR: begin
          slot_q <= free_rd_q;
          free_top_q <= free_top_q - CW'(1);
          if (cnt_q == '0) begin
            front_q <= free_rd_q; back_q <= free_rd_q;
            front_v_q <= value_q; back_v_q <= value_q;
          end else if (first_q) begin
            front_q <= free_rd_q; front_v_q <= value_q;
          end else if (cur_q == back_q) begin
            back_q <= free_rd_q; back_v_q <= value_q;
          end
          cnt_q <= cnt_q + CW'(1);
          state_q <= S_DONE;
        end
        // delete: link_rd gives cur's successor
        S_DEL_RD: state_q <= S_DEL_WT;
        S_DEL_WT: begin
          // victim is the front itself or cur's successor
          slot_q  <= first_q ? cur_q : link_rd_q;
          state_q <= S_DEL_LNK;
        end
        // victim's link read in flight
        S_DEL_LNK: state_q <= S_DEL_FIX;
        S_DEL_FIX: begin
          // link_rd_q holds victim's successor
          free_top_q <= free_top_q + CW'(1);
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            front_q <= '0; back_q <= '0;
          end else if (first_q) begin
            front_q <= link_rd_q;
          end else if (slot_q == back_q) begin
            back_q <= cur_q;
          end
          state_q <= S_DEL_VAL;
        end
        // value of the new front or new back arrives
        S_DEL_VAL: begin
          if (first_q) front_v_q <= val_rd_q;
          else if (back_q == cur_q) back_v_q <= val_rd_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          ouser_q  <= st_q;
          odata_q  <= {2'b00,
                       (cnt_q == '0) ? VW'(0) : back_v_q,
                       (cnt_q == '0) ? VW'(0) : front_v_q,
                       OCW'(cnt_q)};
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/clpe_checker.sv
// Port checker for the circular list positional engine, bound to the top level.
// Depends on clpe_pkg.
module clpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5:0] == 6'd0 |-> m_axis_tdata[69:6] == 64'd0)
    else $error("empty list shows values");
  a_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == clpe_pkg::ST_UNDER |-> m_axis_tdata[5:0] == 6'd0)
    else $error("underflow on non-empty list");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");
endmodule

bind circular_list_positional_engine clpe_checker u_clpe_checker (.*);
